[rtl/core/tsbw_pkg.sv]
// Shared types, constants and helpers for the bilinear texture sampler.
// No dependencies; imported by every module in rtl/core.
package tsbw_pkg;

	localparam int STORE_DEPTH = 4096;
	localparam int ADDR_W      = 12;
	localparam int SIZE_W      = 7;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 7;
	localparam int NUM_TAPS    = 4;

	// Half a texel in Q.16
	localparam logic signed [40:0] HALF_Q16_W = 41'sd32768;
	localparam logic signed [23:0] HALF_Q16_N = 24'sd32768;
	localparam logic [24:0]        ROUND_Q16  = 25'd32768;
	localparam logic [8:0]         ONE_Q8     = 9'd256;
	localparam logic [7:0]         CHAN_FULL  = 8'hFF;

	// Command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Wrap codes
	localparam logic WRAP_REPEAT = 1'b0;
	localparam logic WRAP_CLAMP  = 1'b1;

	// Filter codes
	localparam logic FILT_NEAREST  = 1'b0;
	localparam logic FILT_BILINEAR = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEX_WIDTH  = 3'd0,
		REG_TEX_HEIGHT = 3'd1,
		REG_WRAP_S     = 3'd2,
		REG_WRAP_T     = 3'd3,
		REG_MIN_FILT   = 3'd4,
		REG_MAG_FILT   = 3'd5
	} cfg_reg_t;

	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [31:0]       texel_t;
	typedef logic [16:0]       weight_t;

	// Stage load enables, one per register stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_en_t;

	// Texel write traveling with the pipeline
	typedef struct packed {
		logic   we;
		addr_t  idx;
		texel_t val;
	} store_wr_t;

	// Clamp-to-edge of a signed texel index
	function automatic size_t clamp_axis(input logic signed [25:0] i, input size_t size);
		size_t r;
		if (i < 26'sd0) begin
			r = '0;
		end else if (i >= $signed({19'd0, size})) begin
			r = size - 7'd1;
		end else begin
			r = i[SIZE_W-1:0];
		end
		return r;
	endfunction

	// Next texel under repeat wrapping
	function automatic size_t repeat_next(input size_t i, input size_t size);
		size_t r;
		r = i + 7'd1;
		if (r == size) begin
			r = '0;
		end
		return r;
	endfunction

endpackage

[rtl/core/tsbw_coord.sv]
// Coordinate stages: scale by size, floor, wrap, weights and store addresses.
// Depends on tsbw_pkg.
module tsbw_coord (
	input  logic                   clk,
	input  tsbw_pkg::pipe_en_t     en,
	input  logic                   command,
	input  tsbw_pkg::addr_t        texel_index,
	input  tsbw_pkg::texel_t       texel_value,
	input  logic signed [31:0]     s_coord,
	input  logic signed [31:0]     t_coord,
	input  logic                   bilinear,
	input  logic                   empty,
	input  tsbw_pkg::size_t        w,
	input  tsbw_pkg::size_t        h,
	input  logic                   wrap_s,
	input  logic                   wrap_t,
	output logic                   cmd_s3,
	output tsbw_pkg::store_wr_t    wr_s3,
	output tsbw_pkg::addr_t        addr_s3 [tsbw_pkg::NUM_TAPS],
	output tsbw_pkg::weight_t      wgt_s3 [tsbw_pkg::NUM_TAPS],
	output logic                   empty_s3
);
	import tsbw_pkg::*;

	// stage 1 regs
	logic signed [39:0] sfull_s1, tfull_s1;
	logic [22:0]        sfrac_s1, tfrac_s1;
	logic               cmd_s1, bil_s1, empty_s1;
	addr_t              idx_s1, idx_s2;
	texel_t             val_s1, val_s2;
	// stage 2 regs
	size_t              x0_s2, x1_s2, y0_s2, y1_s2;
	logic [7:0]         ax_s2, ay_s2;
	logic               cmd_s2, empty_s2;

	logic signed [40:0] sp, tp;
	logic signed [23:0] sf, tf;
	logic signed [25:0] sx0, sx1, ty0, ty1;
	logic signed [7:0]  sr, tr;
	size_t              xr0, yr0;
	logic [8:0]         wx0, wy0;

	// stage 1: products of coordinate and size
	always_ff @(posedge clk) begin
		if (en.s1) begin
			sfull_s1 <= s_coord * $signed({1'b0, w});
			tfull_s1 <= t_coord * $signed({1'b0, h});
			sfrac_s1 <= s_coord[15:0] * w;
			tfrac_s1 <= t_coord[15:0] * h;
			cmd_s1   <= command;
			bil_s1   <= bilinear;
			empty_s1 <= empty;
			idx_s1   <= texel_index;
			val_s1   <= texel_value;
		end
	end

	// stage 2: half-texel shift, floor, wrap
	always_comb begin
		sp = $signed({sfull_s1[39], sfull_s1});
		tp = $signed({tfull_s1[39], tfull_s1});
		sf = $signed({1'b0, sfrac_s1});
		tf = $signed({1'b0, tfrac_s1});
		if (bil_s1) begin
			sp = sp - HALF_Q16_W;
			tp = tp - HALF_Q16_W;
			sf = sf - HALF_Q16_N;
			tf = tf - HALF_Q16_N;
		end
		sx0 = $signed({sp[40], sp[40:16]});
		ty0 = $signed({tp[40], tp[40:16]});
		sx1 = sx0 + 26'sd1;
		ty1 = ty0 + 26'sd1;
		// fraction part alone gives the index modulo size
		sr  = sf[23:16];
		tr  = tf[23:16];
		xr0 = (sr < 8'sd0) ? w - 7'd1 : sr[SIZE_W-1:0];
		yr0 = (tr < 8'sd0) ? h - 7'd1 : tr[SIZE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			if (wrap_s == WRAP_CLAMP) begin
				x0_s2 <= clamp_axis(sx0, w);
				x1_s2 <= clamp_axis(sx1, w);
			end else begin
				x0_s2 <= xr0;
				x1_s2 <= repeat_next(xr0, w);
			end
			if (wrap_t == WRAP_CLAMP) begin
				y0_s2 <= clamp_axis(ty0, h);
				y1_s2 <= clamp_axis(ty1, h);
			end else begin
				y0_s2 <= yr0;
				y1_s2 <= repeat_next(yr0, h);
			end
			// nearest: all weight on the first tap
			ax_s2    <= bil_s1 ? sp[15:8] : 8'd0;
			ay_s2    <= bil_s1 ? tp[15:8] : 8'd0;
			cmd_s2   <= cmd_s1;
			empty_s2 <= empty_s1;
			idx_s2   <= idx_s1;
			val_s2   <= val_s1;
		end
	end

	// stage 3: row-major addresses and tap weights
	assign wx0 = ONE_Q8 - {1'b0, ax_s2};
	assign wy0 = ONE_Q8 - {1'b0, ay_s2};

	always_ff @(posedge clk) begin
		if (en.s3) begin
			addr_s3[0] <= ADDR_W'(y0_s2 * w + {7'd0, x0_s2});
			addr_s3[1] <= ADDR_W'(y0_s2 * w + {7'd0, x1_s2});
			addr_s3[2] <= ADDR_W'(y1_s2 * w + {7'd0, x0_s2});
			addr_s3[3] <= ADDR_W'(y1_s2 * w + {7'd0, x1_s2});
			wgt_s3[0]  <= {8'd0, wx0} * {8'd0, wy0};
			wgt_s3[1]  <= {9'd0, ax_s2} * {8'd0, wy0};
			wgt_s3[2]  <= {8'd0, wx0} * {9'd0, ay_s2};
			wgt_s3[3]  <= {9'd0, ax_s2} * {9'd0, ay_s2};
			cmd_s3     <= cmd_s2;
			empty_s3   <= empty_s2;
			wr_s3.we   <= (cmd_s2 == CMD_WRITE);
			wr_s3.idx  <= idx_s2;
			wr_s3.val  <= val_s2;
		end
	end

endmodule

[rtl/core/tsbw_store.sv]
// Texel store: four copies, one read port each, all written together.
// Depends on tsbw_pkg.
module tsbw_store (
	input  logic                   clk,
	input  logic                   en,
	input  logic                   valid,
	input  tsbw_pkg::store_wr_t    wr,
	input  tsbw_pkg::addr_t        addr [tsbw_pkg::NUM_TAPS],
	output tsbw_pkg::texel_t       rd_s4 [tsbw_pkg::NUM_TAPS]
);
	import tsbw_pkg::*;

	for (genvar k = 0; k < NUM_TAPS; k++) begin : g_copy
		texel_t mem [STORE_DEPTH];

		// write in pipeline order so later samples see it
		always_ff @(posedge clk) begin
			if (en && valid && wr.we) begin
				mem[wr.idx] <= wr.val;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rd_s4[k] <= mem[addr[k]];
			end
		end
	end

endmodule

[rtl/core/tsbw_blend.sv]
// Blend stages: per-channel weighted products, then rounded sum.
// Depends on tsbw_pkg.
module tsbw_blend (
	input  logic                   clk,
	input  tsbw_pkg::pipe_en_t     en,
	input  tsbw_pkg::weight_t      wgt_s3 [tsbw_pkg::NUM_TAPS],
	input  logic                   empty_s3,
	input  tsbw_pkg::texel_t       rd_s4 [tsbw_pkg::NUM_TAPS],
	output logic [7:0]             alpha_out,
	output logic [7:0]             red_out,
	output logic [7:0]             green_out,
	output logic [7:0]             blue_out
);
	import tsbw_pkg::*;

	weight_t     wgt_s4 [NUM_TAPS];
	logic        empty_s4, empty_s5;
	logic [24:0] prod_s5 [NUM_TAPS][4];
	logic [24:0] sum [4];
	logic [7:0]  chan [4];

	always_ff @(posedge clk) begin
		if (en.s4) begin
			wgt_s4   <= wgt_s3;
			empty_s4 <= empty_s3;
		end
	end

	// stage 5: tap times weight, channel c=0 is alpha
	always_ff @(posedge clk) begin
		if (en.s5) begin
			for (int k = 0; k < NUM_TAPS; k++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s5[k][c] <= rd_s4[k][31-8*c -: 8] * wgt_s4[k];
				end
			end
			empty_s5 <= empty_s4;
		end
	end

	// stage 6: sum and round
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sum[c]  = prod_s5[0][c] + prod_s5[1][c] + prod_s5[2][c] + prod_s5[3][c]
				+ ROUND_Q16;
			chan[c] = empty_s5 ? CHAN_FULL : sum[c][23:16];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			alpha_out <= chan[0];
			red_out   <= chan[1];
			green_out <= chan[2];
			blue_out  <= chan[3];
		end
	end

endmodule

[rtl/core/texture_sampler_bilinear_wrap.sv]
// Top level of the bilinear texture sampler: config registers, stage control.
// Depends on tsbw_pkg, tsbw_coord, tsbw_store, tsbw_blend.
//
//  port group  | dir | handshake          | payload
//  ------------+-----+--------------------+-----------------------------------------
//  input word  | in  | in_valid/in_ready  | command texel_index texel_value s/t magnifying
//  result word | out | out_valid/out_ready| alpha_out red_out green_out blue_out
//  config      | in  | cfg_we             | cfg_index cfg_data
//
// Six register stages; one word enters per clock while no stall holds in_ready low,
// and a sample result is valid in stage 6. Writes reach the store in stage 4 and give no result.
// Each stage holds a valid bit and loads when it is empty or its successor moves,
// so a stalled output holds only the stages behind it and bubbles are filled.
// arst_n resets valid bits and config registers; the store is undefined until written.
module texture_sampler_bilinear_wrap #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic [11:0]                         texel_index,
	input  logic [31:0]                         texel_value,
	input  logic signed [31:0]                  s_coord,
	input  logic signed [31:0]                  t_coord,
	input  logic                                magnifying,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          alpha_out,
	output logic [7:0]                          red_out,
	output logic [7:0]                          green_out,
	output logic [7:0]                          blue_out,
	input  logic                                cfg_we,
	input  logic [tsbw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tsbw_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import tsbw_pkg::*;

	localparam int WCAP = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
	localparam int HCAP = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;

	size_t     tex_width_q, tex_height_q;
	logic      wrap_s_q, wrap_t_q, min_filt_q, mag_filt_q;
	size_t     w, h;
	logic      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	pipe_en_t  en;
	logic      cmd_s3, empty_s3;
	store_wr_t wr_s3;
	addr_t     addr_s3 [NUM_TAPS];
	weight_t   wgt_s3 [NUM_TAPS];
	texel_t    rd_s4 [NUM_TAPS];

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= '0;
			tex_height_q <= '0;
			wrap_s_q     <= WRAP_REPEAT;
			wrap_t_q     <= WRAP_REPEAT;
			min_filt_q   <= FILT_BILINEAR;
			mag_filt_q   <= FILT_BILINEAR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEX_WIDTH:  tex_width_q  <= cfg_data;
				REG_TEX_HEIGHT: tex_height_q <= cfg_data;
				REG_WRAP_S:     wrap_s_q     <= cfg_data[0];
				REG_WRAP_T:     wrap_t_q     <= cfg_data[0];
				REG_MIN_FILT:   min_filt_q   <= cfg_data[0];
				REG_MAG_FILT:   mag_filt_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign w = (tex_width_q > SIZE_W'(WCAP)) ? SIZE_W'(WCAP) : tex_width_q;
	assign h = (tex_height_q > SIZE_W'(HCAP)) ? SIZE_W'(HCAP) : tex_height_q;

	// stage enables ripple back from the output
	assign en.s6    = !v_s6 || out_ready;
	assign en.s5    = !v_s5 || en.s6;
	assign en.s4    = !v_s4 || en.s5;
	assign en.s3    = !v_s3 || en.s4;
	assign en.s2    = !v_s2 || en.s3;
	assign en.s1    = !v_s1 || en.s2;
	assign in_ready = en.s1;
	assign out_valid = v_s6;

	// valid bits; writes drop out after the store stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3 && (cmd_s3 == CMD_SAMPLE);
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
		end
	end

	tsbw_coord u_coord (
		.clk         (clk),
		.en          (en),
		.command     (command),
		.texel_index (texel_index),
		.texel_value (texel_value),
		.s_coord     (s_coord),
		.t_coord     (t_coord),
		.bilinear    (magnifying ? mag_filt_q : min_filt_q),
		.empty       ((tex_width_q == '0) || (tex_height_q == '0)),
		.w           (w),
		.h           (h),
		.wrap_s      (wrap_s_q),
		.wrap_t      (wrap_t_q),
		.cmd_s3      (cmd_s3),
		.wr_s3       (wr_s3),
		.addr_s3     (addr_s3),
		.wgt_s3      (wgt_s3),
		.empty_s3    (empty_s3)
	);

	tsbw_store u_store (
		.clk   (clk),
		.en    (en.s4),
		.valid (v_s3),
		.wr    (wr_s3),
		.addr  (addr_s3),
		.rd_s4 (rd_s4)
	);

	tsbw_blend u_blend (
		.clk       (clk),
		.en        (en),
		.wgt_s3    (wgt_s3),
		.empty_s3  (empty_s3),
		.rd_s4     (rd_s4),
		.alpha_out (alpha_out),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

endmodule

[sim/testbench.sv]
// Self-checking testbench for texture_sampler_bilinear_wrap.
// Depends on tsbw_pkg and the sampler RTL; predicts every sample result in a scoreboard class.
module testbench;
	import tsbw_pkg::*;

	localparam int          HALF_PERIOD = 10;
	localparam int          WATCHDOG    = 4000;
	localparam int          DRAIN       = 16;
	localparam int          MAX_DIM     = 64;
	localparam int          FILL        = 256;
	localparam logic [2:0]  REG_SPARE_A = 3'd6;
	localparam logic [2:0]  REG_SPARE_B = 3'd7;

	// Sampler predictor plus queue of expected texels
	class sampler_board;
		texel_t      mem [STORE_DEPTH];
		logic [6:0]  width_r, height_r;
		logic        wrap_s_r, wrap_t_r, min_filt_r, mag_filt_r;
		texel_t      texel_q [$];
		int          errors;

		function new();
			width_r = '0; height_r = '0;
			wrap_s_r = WRAP_REPEAT; wrap_t_r = WRAP_REPEAT;
			min_filt_r = FILT_BILINEAR; mag_filt_r = FILT_BILINEAR;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [6:0] data);
			case (idx)
				REG_TEX_WIDTH:  width_r    = data;
				REG_TEX_HEIGHT: height_r   = data;
				REG_WRAP_S:     wrap_s_r   = data[0];
				REG_WRAP_T:     wrap_t_r   = data[0];
				REG_MIN_FILT:   min_filt_r = data[0];
				REG_MAG_FILT:   mag_filt_r = data[0];
				default: ;
			endcase
		endfunction

		function longint wrap_idx(longint i, longint size, logic mode);
			longint r;
			if (mode == WRAP_CLAMP) begin
				r = (i < 0) ? 0 : ((i >= size) ? size - 1 : i);
			end else begin
				r = i % size;
				if (r < 0) r += size;
			end
			return r;
		endfunction

		function texel_t fetch(longint x, longint y, longint w, longint h);
			longint cx, cy;
			cx = wrap_idx(x, w, wrap_s_r);
			cy = wrap_idx(y, h, wrap_t_r);
			return mem[(cy * w + cx) % STORE_DEPTH];
		endfunction

		// Accepted input word: store a texel or queue the predicted sample
		function void note_word(logic cmd, addr_t idx, texel_t val,
		                        logic signed [31:0] s, logic signed [31:0] t, logic mag);
			longint w, h, sx, ty, x0, y0, ax, ay, acc;
			texel_t p0, p1, p2, p3, res;
			logic   filt;
			if (cmd == CMD_WRITE) begin
				mem[idx] = val;
				return;
			end
			if (width_r == 0 || height_r == 0) begin
				texel_q.push_back(32'hFFFF_FFFF);
				return;
			end
			w = (width_r > MAX_DIM) ? MAX_DIM : width_r;
			h = (height_r > MAX_DIM) ? MAX_DIM : height_r;
			sx = longint'(s) * w;
			ty = longint'(t) * h;
			filt = mag ? mag_filt_r : min_filt_r;
			if (filt == FILT_NEAREST) begin
				texel_q.push_back(fetch(sx >>> 16, ty >>> 16, w, h));
				return;
			end
			sx -= 32768;
			ty -= 32768;
			x0 = sx >>> 16;
			y0 = ty >>> 16;
			ax = (sx & 64'hFFFF) >> 8;
			ay = (ty & 64'hFFFF) >> 8;
			p0 = fetch(x0, y0, w, h);
			p1 = fetch(x0 + 1, y0, w, h);
			p2 = fetch(x0, y0 + 1, w, h);
			p3 = fetch(x0 + 1, y0 + 1, w, h);
			for (int k = 0; k < 4; k++) begin
				acc = longint'(p0[8*k +: 8]) * (256 - ax) * (256 - ay)
				    + longint'(p1[8*k +: 8]) * ax * (256 - ay)
				    + longint'(p2[8*k +: 8]) * (256 - ax) * ay
				    + longint'(p3[8*k +: 8]) * ax * ay + 32768;
				res[8*k +: 8] = acc[23:16];
			end
			texel_q.push_back(res);
		endfunction

		task report(string what, logic [7:0] exp_v, logic [7:0] got_v);
			$display("mismatch %s: expected %02h got %02h at %0t", what, exp_v, got_v, $realtime);
			errors++;
		endtask

		// Accepted result word against the oldest prediction
		task check_word(logic [7:0] a, logic [7:0] r, logic [7:0] g, logic [7:0] b);
			texel_t e;
			if (texel_q.size() == 0) begin
				$display("unexpected result word %02h%02h%02h%02h at %0t", a, r, g, b, $realtime);
				errors++;
				return;
			end
			e = texel_q.pop_front();
			if (a !== e[31:24]) report("alpha", e[31:24], a);
			if (r !== e[23:16]) report("red", e[23:16], r);
			if (g !== e[15:8]) report("green", e[15:8], g);
			if (b !== e[7:0]) report("blue", e[7:0], b);
		endtask
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, command, magnifying;
	logic [11:0] texel_index;
	logic [31:0] texel_value;
	logic signed [31:0] s_coord, t_coord;
	logic out_valid, out_ready;
	logic [7:0] alpha_out, red_out, green_out, blue_out;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sampler_board sb;
	int tx_idle_pct, rx_stall_pct;
	int hold_req;
	int hold_left;
	int quiet_cycles;

	texture_sampler_bilinear_wrap u_top (.*);

	// Clock
	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// Receiver: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_word(alpha_out, red_out, green_out, blue_out);
	end

	// Watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_word(logic cmd, addr_t idx, texel_t val,
	                         logic signed [31:0] s, logic signed [31:0] t, logic mag);
		int gap;
		gap = 0;
		if (tx_idle_pct > 0) while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		texel_index <= idx;
		texel_value <= val;
		s_coord     <= s;
		t_coord     <= t;
		magnifying  <= mag;
		do @(posedge clk); while (!in_ready);
		sb.note_word(cmd, idx, val, s, t, mag);
	endtask

	task automatic send_sample(logic signed [31:0] s, logic signed [31:0] t, logic mag);
		send_word(CMD_SAMPLE, addr_t'($urandom), $urandom, s, t, mag);
	endtask

	// Wait out every expected word and the pipeline tail, then write all registers
	task automatic set_config(logic [6:0] w, logic [6:0] h, logic ws, logic wt,
	                          logic mn, logic mg);
		in_valid <= 1'b0;
		while (sb.texel_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_TEX_WIDTH;  cfg_data <= w; @(posedge clk); sb.set_reg(REG_TEX_WIDTH, w);
		cfg_index <= REG_TEX_HEIGHT; cfg_data <= h; @(posedge clk); sb.set_reg(REG_TEX_HEIGHT, h);
		cfg_index <= REG_WRAP_S;     cfg_data <= {6'd0, ws}; @(posedge clk);
		sb.set_reg(REG_WRAP_S, {6'd0, ws});
		cfg_index <= REG_WRAP_T;     cfg_data <= {6'd0, wt}; @(posedge clk);
		sb.set_reg(REG_WRAP_T, {6'd0, wt});
		cfg_index <= REG_MIN_FILT;   cfg_data <= {6'd0, mn}; @(posedge clk);
		sb.set_reg(REG_MIN_FILT, {6'd0, mn});
		cfg_index <= REG_MAG_FILT;   cfg_data <= {6'd0, mg}; @(posedge clk);
		sb.set_reg(REG_MAG_FILT, {6'd0, mg});
		// spare indexes must be ignored
		cfg_index <= ($urandom_range(1) != 0) ? REG_SPARE_A : REG_SPARE_B;
		cfg_data <= 7'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_coord();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $signed($urandom_range(0, 8 * 65536)) - 32'sd262144;
			2: return $signed({16'($urandom_range(0, 12)), 16'd0}) - 32'sd393216;
			3: return $signed($urandom_range(0, 2 * 65536)) - 32'sd65536;
			default: case ($urandom_range(3))
				0: return 32'sh8000_0000;
				1: return 32'sh7FFF_FFFF;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		endcase
	endfunction

	task automatic random_phase(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 15)
				send_word(CMD_WRITE, addr_t'($urandom), $urandom, $urandom, $urandom,
				          1'($urandom_range(1)));
			else
				send_sample(pick_coord(), pick_coord(), 1'($urandom_range(1)));
		end
	endtask

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
			default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
		endcase
	endtask

	// Main sequence
	initial begin
		sb = new();
		tx_idle_pct = 0; rx_stall_pct = 0;
		hold_req = 0; hold_left = 0; quiet_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0; command = CMD_WRITE; texel_index = '0; texel_value = '0;
		s_coord = '0; t_coord = '0; magnifying = 1'b0;
		out_ready = 1'b0;
		cfg_we = 1'b0; cfg_index = REG_TEX_WIDTH; cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty texture right after reset gives white
		send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
		send_sample(32'sd0, 32'sd0, 1'b0);

		// Fill the low store; every texture below stays within this area
		for (int i = 0; i < FILL; i++)
			send_word(CMD_WRITE, addr_t'(i), $urandom, $urandom, $urandom,
			          1'($urandom_range(1)));
		send_word(CMD_WRITE, 12'd0, 32'h0000_0000, 32'sd0, 32'sd0, 1'b0);
		send_word(CMD_WRITE, 12'hFFF, 32'hFFFF_FFFF, 32'sd0, 32'sd0, 1'b1);

		// Directed: extremes of coordinates and both filters, tiny and full-width textures
		set_config(7'd4, 7'd4, WRAP_REPEAT, WRAP_CLAMP, FILT_NEAREST, FILT_BILINEAR);
		send_sample(32'sh8000_0000, 32'sh8000_0000, 1'b0);
		send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
		send_sample(32'sd0, 32'sd0, 1'b1);
		send_sample(-32'sd1, -32'sd1, 1'b0);
		send_sample(32'sd65535, 32'sd65536, 1'b1);
		send_sample(32'sd32768, 32'sd49152, 1'b1);
		set_config(7'd64, 7'd4, WRAP_CLAMP, WRAP_REPEAT, FILT_BILINEAR, FILT_NEAREST);
		send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
		send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
		send_sample(32'sd65535, -32'sd1, 1'b0);
		send_sample(-32'sd65536, 32'sd131072, 1'b0);
		// oversized sizes count as the maximum
		set_config(7'd127, 7'd3, WRAP_CLAMP, WRAP_CLAMP, FILT_BILINEAR, FILT_BILINEAR);
		send_sample(32'sd65536, 32'sd65536, 1'b1);
		send_sample(32'sd32768, 32'sd0, 1'b0);
		send_sample(-32'sd1, 32'sh7FFF_FFFF, 1'b1);
		set_config(7'd2, 7'd127, WRAP_REPEAT, WRAP_CLAMP, FILT_NEAREST, FILT_BILINEAR);
		send_sample(32'sd65536, 32'sd65536, 1'b1);
		send_sample(32'sd32768, 32'sh7FFF_FFFF, 1'b0);
		// empty on one axis only
		set_config(7'd0, 7'd9, WRAP_REPEAT, WRAP_REPEAT, FILT_NEAREST, FILT_NEAREST);
		send_sample(32'sd12345, 32'sd6789, 1'b0);
		set_config(7'd9, 7'd0, WRAP_REPEAT, WRAP_REPEAT, FILT_BILINEAR, FILT_NEAREST);
		send_sample(32'sd12345, 32'sd6789, 1'b1);

		// Random phases over a spread of settings
		set_config(7'd1, 7'd1, WRAP_REPEAT, WRAP_REPEAT, FILT_BILINEAR, FILT_BILINEAR);
		set_idling(0);
		hold_req = 400;
		random_phase(60);
		for (int ph = 1; ph < 9; ph++) begin
			case (ph)
				1: set_config(7'd64, 7'd4, WRAP_REPEAT, WRAP_REPEAT, FILT_BILINEAR, FILT_NEAREST);
				2: set_config(7'd1, 7'd64, WRAP_CLAMP, WRAP_CLAMP, FILT_NEAREST, FILT_BILINEAR);
				3: set_config(7'd5, 7'd3, WRAP_REPEAT, WRAP_CLAMP, FILT_BILINEAR, FILT_BILINEAR);
				4: set_config(7'd100, 7'd2, WRAP_CLAMP, WRAP_REPEAT, FILT_NEAREST, FILT_NEAREST);
				5: set_config(7'd0, 7'd0, WRAP_CLAMP, WRAP_CLAMP, FILT_BILINEAR, FILT_BILINEAR);
				default: set_config(7'($urandom_range(1, 16)), 7'($urandom_range(1, 16)),
				                    1'($urandom_range(1)), 1'($urandom_range(1)),
				                    1'($urandom_range(1)), 1'($urandom_range(1)));
			endcase
			set_idling(ph);
			if (ph == 6) hold_req = 300;
			random_phase(ph == 5 ? 30 : 60);
		end

		// Drain
		in_valid <= 1'b0;
		while (sb.texel_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
